[rtl/qhp_pkg.sv]
package qhp_pkg;

    // Header byte fields
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TYPE_W = 7;
    localparam int unsigned LEN_W  = 5;

    // Type limits
    localparam logic [TYPE_W-1:0] LONG_TYPE_MAX         = 7'd4;
    localparam logic [TYPE_W-1:0] SHORT_TYPE_MAX        = 7'd2;
    localparam logic [TYPE_W-1:0] LONG_TYPE_NEGOTIATION = 7'd0;
    localparam logic [TYPE_W-1:0] SHORT_TYPE_PN1        = 7'd0;
    localparam logic [TYPE_W-1:0] SHORT_TYPE_PN2        = 7'd1;

    // Byte positions and lengths
    localparam logic [LEN_W-1:0] CID_BYTES       = 5'd8;
    localparam logic [LEN_W-1:0] VERSION_END     = 5'd12;
    localparam logic [LEN_W-1:0] LEN_NEGOTIATION = 5'd13;
    localparam logic [LEN_W-1:0] LEN_LONG        = 5'd17;
    localparam logic [LEN_W-1:0] LEN_FIRST       = 5'd1;
    localparam logic [LEN_W-1:0] PN_LEN_1        = 5'd1;
    localparam logic [LEN_W-1:0] PN_LEN_2        = 5'd2;
    localparam logic [LEN_W-1:0] PN_LEN_4        = 5'd4;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Output word widths
    localparam int unsigned HDR_W   = 143;
    localparam int unsigned TDATA_W = 144;

    // Header fields, is_long in the lowest bit
    typedef struct packed {
        logic [LEN_W-1:0]  header_bytes;
        logic [31:0]       packet_number;
        logic [31:0]       version_word;
        logic [63:0]       conn_id;
        logic [TYPE_W-1:0] packet_type;
        logic              key_phase;
        logic              has_conn_id;
        logic              is_long;
    } qhp_hdr_t;

    typedef struct packed {
        logic     status;
        qhp_hdr_t hdr;
    } qhp_result_t;

endpackage

[rtl/qhp_parse_core.sv]
module qhp_parse_core
    import qhp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              first_byte,
    output logic              res_valid,
    output qhp_result_t       res
);

    logic              active_reg, active_next;
    logic [LEN_W-1:0]  index_reg, index_next;
    logic [LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic              form_reg, form_next;
    logic              flag_reg, flag_next;
    logic              phase_reg, phase_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic [63:0]       cid_reg, cid_next;
    logic [31:0]       ver_reg, ver_next;
    logic [31:0]       pn_reg, pn_next;

    logic              type_err;
    logic              has_cid;
    logic [LEN_W-1:0]  pn_len;
    logic [LEN_W-1:0]  cid_end;

    function automatic qhp_result_t build_res(
        input logic              form,
        input logic              flag,
        input logic              phase,
        input logic [TYPE_W-1:0] ptype,
        input logic [63:0]       cid,
        input logic [31:0]       ver,
        input logic [31:0]       pn,
        input logic [LEN_W-1:0]  len,
        input logic              status
    );
        qhp_result_t r;
        r.status            = status;
        r.hdr.is_long       = form;
        r.hdr.has_conn_id   = form | flag;
        r.hdr.key_phase     = form ? 1'b0 : phase;
        r.hdr.packet_type   = ptype;
        r.hdr.conn_id       = (form | flag) ? cid : 64'd0;
        r.hdr.version_word  = form ? ver : 32'd0;
        r.hdr.packet_number = pn;
        r.hdr.header_bytes  = len;
        return r;
    endfunction

    // Next-state and result for one byte
    always_comb begin
        active_next  = active_reg;
        index_next   = index_reg;
        exp_len_next = exp_len_reg;
        form_next    = form_reg;
        flag_next    = flag_reg;
        phase_next   = phase_reg;
        type_next    = type_reg;
        cid_next     = cid_reg;
        ver_next     = ver_reg;
        pn_next      = pn_reg;
        res_valid    = 1'b0;
        type_err     = 1'b0;
        pn_len       = PN_LEN_4;
        has_cid      = form_reg | flag_reg;
        cid_end      = has_cid ? CID_BYTES : '0;
        res          = build_res(form_reg, flag_reg, phase_reg, type_reg, cid_reg,
                                 ver_reg, pn_reg, exp_len_reg, STATUS_OK);

        if (byte_valid && first_byte) begin
            // first byte: decode form and type
            cid_next  = '0;
            ver_next  = '0;
            pn_next   = '0;
            form_next = data_byte[7];
            if (data_byte[7]) begin
                flag_next  = 1'b0;
                phase_next = 1'b0;
                type_next  = data_byte[6:0];
                type_err   = (data_byte[6:0] > LONG_TYPE_MAX);
                exp_len_next = (data_byte[6:0] == LONG_TYPE_NEGOTIATION) ?
                               LEN_NEGOTIATION : LEN_LONG;
            end else begin
                flag_next  = data_byte[6];
                phase_next = data_byte[5];
                type_next  = {2'b00, data_byte[4:0]};
                type_err   = ({2'b00, data_byte[4:0]} > SHORT_TYPE_MAX);
                case ({2'b00, data_byte[4:0]})
                    SHORT_TYPE_PN1: pn_len = PN_LEN_1;
                    SHORT_TYPE_PN2: pn_len = PN_LEN_2;
                    default:        pn_len = PN_LEN_4;
                endcase
                exp_len_next = LEN_FIRST + (data_byte[6] ? CID_BYTES : '0) + pn_len;
            end
            if (type_err) begin
                active_next  = 1'b0;
                index_next   = '0;
                exp_len_next = '0;
                res_valid    = 1'b1;
                res = build_res(form_next, flag_next, phase_next, type_next,
                                64'd0, 32'd0, 32'd0, LEN_FIRST, STATUS_ERR);
            end else begin
                active_next = 1'b1;
                index_next  = LEN_FIRST;
            end
        end else if (byte_valid && active_reg) begin
            // shift the byte into the field this position belongs to
            if (index_reg <= cid_end) begin
                cid_next = {cid_reg[55:0], data_byte};
            end else if (form_reg && (index_reg <= VERSION_END)) begin
                ver_next = {ver_reg[23:0], data_byte};
            end else begin
                pn_next = {pn_reg[23:0], data_byte};
            end
            index_next = index_reg + LEN_FIRST;
            if (index_next >= exp_len_reg) begin
                active_next = 1'b0;
                index_next  = '0;
                res_valid   = 1'b1;
                res = build_res(form_reg, flag_reg, phase_reg, type_reg, cid_next,
                                ver_next, pn_next, exp_len_reg, STATUS_OK);
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            index_reg   <= '0;
            exp_len_reg <= '0;
        end else begin
            active_reg  <= active_next;
            index_reg   <= index_next;
            exp_len_reg <= exp_len_next;
        end
    end

    // Header fields, loaded on the first byte before any use
    always_ff @(posedge aclk) begin
        form_reg  <= form_next;
        flag_reg  <= flag_next;
        phase_reg <= phase_next;
        type_reg  <= type_next;
        cid_reg   <= cid_next;
        ver_reg   <= ver_next;
        pn_reg    <= pn_next;
    end

endmodule

[rtl/quic_header_parser.sv]
// A result word is registered once the last header byte is accepted.
// Throughput: one byte per cycle while s_tready is high; state updates in a single pass.
// A two-entry output (result register plus skid register) keeps input open while
// one result waits; input stalls only when both entries are full.
// Reset: aresetn synchronous, active low; parser goes idle and both entries empty.
module quic_header_parser
    import qhp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic               s_tuser,   // [0] first_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // is_long, has_conn_id, key_phase, packet_type,
                                          // conn_id, version_word, packet_number,
                                          // header_bytes, zero pad
    output logic               m_tuser    // [0] status
);

    logic        s_accept;
    logic        res_valid;
    qhp_result_t res;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    qhp_result_t out_reg, out_next;
    qhp_result_t skid_reg, skid_next;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    qhp_parse_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_accept),
        .data_byte  (s_tdata),
        .first_byte (s_tuser),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Output register with skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            if (out_valid_reg && !m_tready) begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end else begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.hdr};
    assign m_tuser  = out_reg.status;

endmodule

[rtl/qhp_checker.sv]
module qhp_checker
    import qhp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tuser
);

    qhp_hdr_t hdr;
    assign hdr = m_tdata[HDR_W-1:0];

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // input only closes while a result word is waiting
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result word waiting");

    // a rejected type reports one byte and no gathered fields
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_ERR) |->
            (hdr.header_bytes == LEN_FIRST) && (hdr.conn_id == 64'd0) &&
            (hdr.version_word == 32'd0) && (hdr.packet_number == 32'd0))
        else $error("reject word carries header data");

    // complete long header: 13 or 17 bytes, connection id present, no phase bit
    a_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_OK) && hdr.is_long |->
            hdr.has_conn_id && !hdr.key_phase &&
            ((hdr.header_bytes == LEN_NEGOTIATION) || (hdr.header_bytes == LEN_LONG)))
        else $error("bad long header word");

    // complete short header carries no version and a plausible length
    a_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_OK) && !hdr.is_long |->
            (hdr.version_word == 32'd0) && (hdr.header_bytes >= 5'd2) &&
            (hdr.header_bytes <= 5'd13) && (hdr.packet_type <= SHORT_TYPE_MAX))
        else $error("bad short header word");

endmodule

bind quic_header_parser qhp_checker u_qhp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/quic_header_parser_tb.sv]
module quic_header_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qhp_pkg::*;

    localparam int RANDOM_WORDS = 950;
    localparam int DIRECTED_ROWS = 25;
    localparam int HOLD_OFF_CYCLES = 400;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;   // [7:0] data_byte
    logic               s_tuser;   // [0] first_byte
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // is_long, has_conn_id, key_phase, packet_type[6:0],
                                   // conn_id[63:0], version_word[31:0],
                                   // packet_number[31:0], header_bytes[4:0], zero pad
    logic               m_tuser;   // [0] status

    quic_header_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Directed stimulus row; result is only used when typed is set
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        typed;
        qhp_result_t result;
    } dir_row_t;

    dir_row_t    dir_rows [0:DIRECTED_ROWS-1];
    qhp_result_t pending_headers [$];
    int          fail_count;
    int          parsed_words;
    int          headers_seen;
    logic        send_burst;
    logic        recv_burst;

    // Header parse state, mirrors the block
    logic        hp_active;
    logic [4:0]  hp_index;
    logic [4:0]  hp_len;
    logic        hp_long;
    logic        hp_cidf;
    logic        hp_phase;
    logic [6:0]  hp_type;
    logic [63:0] hp_cid;
    logic [31:0] hp_ver;
    logic [31:0] hp_pn;

    function automatic qhp_result_t make_result(
        input logic        lng,
        input logic        has_cid,
        input logic        kp,
        input logic [6:0]  ptype,
        input logic [63:0] cid,
        input logic [31:0] ver,
        input logic [31:0] pn,
        input logic [4:0]  len,
        input logic        st
    );
        qhp_result_t r;
        r.status             = st;
        r.hdr.is_long        = lng;
        r.hdr.has_conn_id    = has_cid;
        r.hdr.key_phase      = kp;
        r.hdr.packet_type    = ptype;
        r.hdr.conn_id        = cid;
        r.hdr.version_word   = ver;
        r.hdr.packet_number  = pn;
        r.hdr.header_bytes   = len;
        return r;
    endfunction

    // Parse one accepted byte; got is set when the byte closes a header
    task automatic parse_byte(input logic [7:0] b, input logic f,
                              output logic got, output qhp_result_t r);
        logic       bad_type;
        logic       has_cid;
        logic [4:0] pn_len;
        got = 1'b0;
        r   = '0;
        if (f) begin
            parsed_words++;
            hp_cid  = '0;
            hp_ver  = '0;
            hp_pn   = '0;
            hp_long = b[7];
            if (b[7]) begin
                hp_cidf  = 1'b0;
                hp_phase = 1'b0;
                hp_type  = b[6:0];
                bad_type = hp_type > LONG_TYPE_MAX;
                hp_len   = (hp_type == LONG_TYPE_NEGOTIATION) ? LEN_NEGOTIATION : LEN_LONG;
            end else begin
                hp_cidf  = b[6];
                hp_phase = b[5];
                hp_type  = {2'b00, b[4:0]};
                bad_type = hp_type > SHORT_TYPE_MAX;
                pn_len   = (hp_type == SHORT_TYPE_PN1) ? PN_LEN_1 :
                           (hp_type == SHORT_TYPE_PN2) ? PN_LEN_2 : PN_LEN_4;
                hp_len   = LEN_FIRST + (b[6] ? CID_BYTES : 5'd0) + pn_len;
            end
            if (bad_type) begin
                // unknown type: error word right away, then idle
                got = 1'b1;
                r   = make_result(hp_long, hp_long | hp_cidf, hp_long ? 1'b0 : hp_phase,
                                  hp_type, '0, '0, '0, LEN_FIRST, STATUS_ERR);
                hp_active = 1'b0;
                hp_index  = '0;
                hp_len    = '0;
            end else begin
                hp_active = 1'b1;
                hp_index  = 5'd1;
            end
        end else if (hp_active) begin
            parsed_words++;
            has_cid = hp_long | hp_cidf;
            if (hp_index <= (has_cid ? CID_BYTES : 5'd0))
                hp_cid = {hp_cid[55:0], b};
            else if (hp_long && hp_index <= VERSION_END)
                hp_ver = {hp_ver[23:0], b};
            else
                hp_pn = {hp_pn[23:0], b};
            hp_index = hp_index + 5'd1;
            if (hp_index >= hp_len) begin
                got = 1'b1;
                r   = make_result(hp_long, has_cid, hp_long ? 1'b0 : hp_phase, hp_type,
                                  has_cid ? hp_cid : 64'd0, hp_long ? hp_ver : 32'd0,
                                  hp_pn, hp_len, STATUS_OK);
                hp_active = 1'b0;
                hp_index  = '0;
            end
        end
    endtask

    // Offer one byte after a random gap; predict once it is taken
    task automatic send_word(input logic [7:0] b, input logic f,
                             input logic typed, input qhp_result_t typed_res);
        int          gap;
        logic        got;
        qhp_result_t r;
        if ($urandom_range(0, 63) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_byte(b, f, got, r);
        if (typed)
            pending_headers.push_back(typed_res);
        else if (got)
            pending_headers.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
            fail_count++;
        end
    endtask

    // Stimulus: reset, directed table, then random headers
    initial begin
        logic [7:0] b;
        int         pick;
        int         n;

        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= 1'b0;
        aresetn    <= 1'b0;
        fail_count   = 0;
        parsed_words = 0;
        send_burst   = 1'b0;
        hp_active = 1'b0;
        hp_index  = '0;
        hp_len    = '0;
        hp_long   = 1'b0;
        hp_cidf   = 1'b0;
        hp_phase  = 1'b0;
        hp_type   = '0;
        hp_cid    = '0;
        hp_ver    = '0;
        hp_pn     = '0;

        // stray byte right after reset, ignored
        dir_rows[0]  = '{8'h5A, 1'b0, 1'b0, '0};
        // unknown types: long 5, long max, short max with all flags, short 3
        dir_rows[1]  = '{8'h85, 1'b1, 1'b1,
                         make_result(1'b1, 1'b1, 1'b0, 7'd5, '0, '0, '0, LEN_FIRST, STATUS_ERR)};
        dir_rows[2]  = '{8'hFF, 1'b1, 1'b1,
                         make_result(1'b1, 1'b1, 1'b0, 7'h7F, '0, '0, '0, LEN_FIRST, STATUS_ERR)};
        dir_rows[3]  = '{8'h7F, 1'b1, 1'b1,
                         make_result(1'b0, 1'b1, 1'b1, 7'h1F, '0, '0, '0, LEN_FIRST, STATUS_ERR)};
        dir_rows[4]  = '{8'h03, 1'b1, 1'b1,
                         make_result(1'b0, 1'b0, 1'b0, 7'd3, '0, '0, '0, LEN_FIRST, STATUS_ERR)};
        // trailing byte after an error is dropped
        dir_rows[5]  = '{8'h11, 1'b0, 1'b0, '0};
        // short, key phase set, one-byte number at max
        dir_rows[6]  = '{8'h20, 1'b1, 1'b0, '0};
        dir_rows[7]  = '{8'hFF, 1'b0, 1'b1,
                         make_result(1'b0, 1'b0, 1'b1, 7'd0, '0, '0, 32'hFF, 5'd2, STATUS_OK)};
        // short two-byte number, restarted by a new start byte mid-header
        dir_rows[8]  = '{8'h01, 1'b1, 1'b0, '0};
        dir_rows[9]  = '{8'h12, 1'b0, 1'b0, '0};
        dir_rows[10] = '{8'h00, 1'b1, 1'b0, '0};
        dir_rows[11] = '{8'h00, 1'b0, 1'b1,
                         make_result(1'b0, 1'b0, 1'b0, 7'd0, '0, '0, '0, 5'd2, STATUS_OK)};
        // long version negotiation: id and version only, 13 bytes
        dir_rows[12] = '{8'h80, 1'b1, 1'b0, '0};
        dir_rows[13] = '{8'hFF, 1'b0, 1'b0, '0};
        dir_rows[14] = '{8'h01, 1'b0, 1'b0, '0};
        dir_rows[15] = '{8'h23, 1'b0, 1'b0, '0};
        dir_rows[16] = '{8'h45, 1'b0, 1'b0, '0};
        dir_rows[17] = '{8'h67, 1'b0, 1'b0, '0};
        dir_rows[18] = '{8'h89, 1'b0, 1'b0, '0};
        dir_rows[19] = '{8'hAB, 1'b0, 1'b0, '0};
        dir_rows[20] = '{8'h00, 1'b0, 1'b0, '0};
        dir_rows[21] = '{8'hFF, 1'b0, 1'b0, '0};
        dir_rows[22] = '{8'h00, 1'b0, 1'b0, '0};
        dir_rows[23] = '{8'h00, 1'b0, 1'b0, '0};
        dir_rows[24] = '{8'h01, 1'b0, 1'b0, '0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_word(dir_rows[i].data, dir_rows[i].first, dir_rows[i].typed,
                      dir_rows[i].result);

        // random headers: mostly complete, some truncated, bad or stray bytes
        while (parsed_words < DIRECTED_ROWS + RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick >= 96) begin
                repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0, 1'b0, '0);
            end else if (pick >= 88) begin
                if ($urandom_range(0, 1))
                    b = {1'b1, 7'($urandom_range(5, 127))};
                else
                    b = {1'b0, 2'($urandom), 5'($urandom_range(3, 31))};
                send_word(b, 1'b1, 1'b0, '0);
            end else begin
                if ($urandom_range(0, 1))
                    b = {1'b1, 7'($urandom_range(0, 4))};
                else
                    b = {1'b0, 2'($urandom), 5'($urandom_range(0, 2))};
                send_word(b, 1'b1, 1'b0, '0);
                n = int'(hp_len) - 1;
                if (pick >= 80)
                    n = $urandom_range(0, n - 1);
                repeat (n) send_word(8'($urandom), 1'b0, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending_headers.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Result side: random stalls, one long hold-off, field checks
    initial begin
        int          gap;
        logic        held;
        qhp_result_t want;
        qhp_hdr_t    seen;

        m_tready    <= 1'b0;
        headers_seen = 0;
        held         = 1'b0;
        recv_burst   = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 63) == 0)
                recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 8);
            if (headers_seen == 40 && !held) begin
                // long hold-off so the output entries fill and input stalls
                gap  = HOLD_OFF_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            headers_seen++;
            seen = m_tdata[HDR_W-1:0];
            if (pending_headers.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %0h", $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_headers.pop_front();
                check_field("status", 64'(want.status), 64'(m_tuser));
                check_field("is_long", 64'(want.hdr.is_long), 64'(seen.is_long));
                check_field("has_conn_id", 64'(want.hdr.has_conn_id),
                            64'(seen.has_conn_id));
                check_field("key_phase", 64'(want.hdr.key_phase), 64'(seen.key_phase));
                check_field("packet_type", 64'(want.hdr.packet_type),
                            64'(seen.packet_type));
                check_field("conn_id", want.hdr.conn_id, seen.conn_id);
                check_field("version_word", 64'(want.hdr.version_word),
                            64'(seen.version_word));
                check_field("packet_number", 64'(want.hdr.packet_number),
                            64'(seen.packet_number));
                check_field("header_bytes", 64'(want.hdr.header_bytes),
                            64'(seen.header_bytes));
                check_field("pad", 64'd0, 64'(m_tdata[TDATA_W-1]));
            end
        end
    end

    // Watchdog
    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
rtl/qhp_pkg.sv
rtl/qhp_parse_core.sv
rtl/quic_header_parser.sv
rtl/qhp_checker.sv
tb/quic_header_parser_tb.sv
